// File: src/hsd_pkg.sv
package hsd_pkg;

   // Field widths of the decoder
   localparam int unsigned CW_BITS   = 64;
   localparam int unsigned SYN_BITS  = 7;
   localparam int unsigned DATA_BITS = 57;
   localparam int unsigned LEN_BITS  = 7;
   localparam int unsigned IDX_BITS  = 6;

   // Length after reset and the ceiling it saturates to
   localparam logic [LEN_BITS-1:0] LEN_RESET = LEN_BITS'(CW_BITS);
   localparam logic [LEN_BITS-1:0] LEN_MAX   = LEN_BITS'(CW_BITS);

   // Status that travels with a word into the output stage
   typedef struct packed {
      logic                valid;
      logic                corrected;
      logic                out_of_range;
      logic [SYN_BITS-1:0] syndrome;
   } rsp_status_type;

   // Codeword bits whose 1-based position has bit i set
   function automatic logic [CW_BITS-1:0] pos_mask(input int unsigned i);
      logic [CW_BITS-1:0] m;
      for (int unsigned b = 0; b < CW_BITS; b++) begin
         m[b] = 1'(((b + 1) >> i) & 1);
      end
      return m;
   endfunction

   // Codeword bit index of the k-th data bit (power-of-two positions skipped)
   function automatic logic [IDX_BITS-1:0] data_bit_index(input int unsigned k);
      int unsigned        n;
      logic [IDX_BITS-1:0] idx;
      n   = 0;
      idx = '0;
      for (int unsigned p = 1; p <= CW_BITS; p++) begin
         if ((p & (p - 1)) != 0) begin
            if (n == k) begin
               idx = IDX_BITS'(p - 1);
            end
            n++;
         end
      end
      return idx;
   endfunction

endpackage

// File: src/hsd_pack.sv
module hsd_pack
   import hsd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  rsp_status_type       status_in,
   input  logic [CW_BITS-1:0]   word_in,
   output logic                 rsp_valid,
   output logic [DATA_BITS-1:0] rsp_data_out,
   output logic [SYN_BITS-1:0]  rsp_syndrome,
   output logic                 rsp_corrected,
   output logic                 rsp_out_of_range
);

   logic [DATA_BITS-1:0] data_in;
   logic [DATA_BITS-1:0] data_ff;
   rsp_status_type       status_ff;

   // Drop parity positions and pack data bits toward the LSB
   for (genvar k = 0; k < DATA_BITS; k++) begin : g_pack
      assign data_in[k] = word_in[data_bit_index(k)];
   end

   // Output register: valid is control, the rest is payload
   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff.valid <= 1'b0;
      end else begin
         status_ff.valid <= status_in.valid;
      end
      status_ff.corrected    <= status_in.corrected;
      status_ff.out_of_range <= status_in.out_of_range;
      status_ff.syndrome     <= status_in.syndrome;
      data_ff                <= data_in;
   end

   assign rsp_valid        = status_ff.valid;
   assign rsp_data_out     = data_ff;
   assign rsp_syndrome     = status_ff.syndrome;
   assign rsp_corrected    = status_ff.corrected;
   assign rsp_out_of_range = status_ff.out_of_range;

endmodule

// File: src/hamming_sec_decoder.sv
// Channel  | Ports                                   | Handshake
// ---------+-----------------------------------------+---------------------------------
// request  | start, busy, req_codeword               | taken when start high, busy low
// response | rsp_valid, rsp_data_out, rsp_syndrome,  | one-cycle strobe, no back-pressure
//          | rsp_corrected, rsp_out_of_range         |
// control  | csr_we, csr_wdata                       | codeword length, written on csr_we
//
// One word enters every cycle; busy is always low.
// The stages are capture and mask, syndrome XOR trees, correction
// flip, then packing into the output register.
// Synchronous reset clears the valid bits of every stage and sets the length to 64.
// The receiver cannot stall, so the pipeline never holds.
module hamming_sec_decoder
   import hsd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [CW_BITS-1:0]   req_codeword,
   output logic                 rsp_valid,
   output logic [DATA_BITS-1:0] rsp_data_out,
   output logic [SYN_BITS-1:0]  rsp_syndrome,
   output logic                 rsp_corrected,
   output logic                 rsp_out_of_range,
   input  logic                 csr_we,
   input  logic [LEN_BITS-1:0]  csr_wdata
);

   logic [LEN_BITS-1:0] len_ff;
   logic [LEN_BITS-1:0] len_sat;

   logic                s0_valid_ff;
   logic [CW_BITS-1:0]  s0_word_in;
   logic [CW_BITS-1:0]  s0_word_ff;
   logic [LEN_BITS-1:0] s0_len_ff;

   logic                s1_valid_ff;
   logic [SYN_BITS-1:0] s1_syn_in;
   logic [SYN_BITS-1:0] s1_syn_ff;
   logic [CW_BITS-1:0]  s1_word_ff;
   logic [LEN_BITS-1:0] s1_len_ff;

   logic                s2_nonzero;
   logic                s2_in_range;
   logic [CW_BITS-1:0]  s2_flip;
   logic [CW_BITS-1:0]  s2_word_in;
   logic [CW_BITS-1:0]  s2_word_ff;
   rsp_status_type      s2_status_in;
   rsp_status_type      s2_status_ff;

   assign busy = 1'b0;

   // Codeword length register
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= LEN_RESET;
      end else if (csr_we) begin
         len_ff <= csr_wdata;
      end
   end

   assign len_sat = (len_ff > LEN_MAX) ? LEN_MAX : len_ff;

   // Stage 0: drop bits at or above the length
   always_comb begin
      for (int unsigned b = 0; b < CW_BITS; b++) begin
         s0_word_in[b] = req_codeword[b] & (LEN_BITS'(b) < len_sat);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= start;
      end
      s0_word_ff <= s0_word_in;
      s0_len_ff  <= len_sat;
   end

   // Stage 1: one XOR tree per syndrome bit
   for (genvar i = 0; i < SYN_BITS; i++) begin : g_syn
      assign s1_syn_in[i] = ^(s0_word_ff & pos_mask(i));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s0_valid_ff;
      end
      s1_syn_ff  <= s1_syn_in;
      s1_word_ff <= s0_word_ff;
      s1_len_ff  <= s0_len_ff;
   end

   // Stage 2: flip the named bit when it lies within the length
   assign s2_nonzero  = (s1_syn_ff != '0);
   assign s2_in_range = (s1_syn_ff <= s1_len_ff);
   assign s2_flip     = (s2_nonzero && s2_in_range)
                        ? (CW_BITS'(1) << IDX_BITS'(s1_syn_ff - SYN_BITS'(1))) : '0;
   assign s2_word_in  = s1_word_ff ^ s2_flip;

   always_comb begin
      s2_status_in.valid        = s1_valid_ff;
      s2_status_in.corrected    = s2_nonzero && s2_in_range;
      s2_status_in.out_of_range = s2_nonzero && !s2_in_range;
      s2_status_in.syndrome     = s1_syn_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_status_ff.valid <= 1'b0;
      end else begin
         s2_status_ff.valid <= s2_status_in.valid;
      end
      s2_status_ff.corrected    <= s2_status_in.corrected;
      s2_status_ff.out_of_range <= s2_status_in.out_of_range;
      s2_status_ff.syndrome     <= s2_status_in.syndrome;
      s2_word_ff                <= s2_word_in;
   end

   // Stage 3: pack data bits into the output register
   hsd_pack u_pack (
      .clock            (clock),
      .reset            (reset),
      .status_in        (s2_status_ff),
      .word_in          (s2_word_ff),
      .rsp_valid        (rsp_valid),
      .rsp_data_out     (rsp_data_out),
      .rsp_syndrome     (rsp_syndrome),
      .rsp_corrected    (rsp_corrected),
      .rsp_out_of_range (rsp_out_of_range)
   );

endmodule

// File: src/hsd_checker.sv
module hsd_checker
   import hsd_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input logic                 rsp_valid,
   input logic [SYN_BITS-1:0]  rsp_syndrome,
   input logic                 rsp_corrected,
   input logic                 rsp_out_of_range
);

   // Every word taken comes out as a result strobe
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##4 rsp_valid)
      else $error("word taken but no result four cycles later");

   // A word is never both corrected and out of range
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_corrected && rsp_out_of_range))
      else $error("corrected and out_of_range both set");

   // A zero syndrome raises no flag, a nonzero one raises exactly one
   a_flags_match_syn: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_syndrome == '0) == !(rsp_corrected || rsp_out_of_range)))
      else $error("flags disagree with syndrome");

   // Reset empties the pipeline
   a_reset_flush: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
      else $error("result strobe right after reset");

endmodule

bind hamming_sec_decoder hsd_checker u_hsd_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_syndrome     (rsp_syndrome),
   .rsp_corrected    (rsp_corrected),
   .rsp_out_of_range (rsp_out_of_range)
);
